/* rtl/cfx_pkg.sv */
// Shared types and constants for the passthrough/render crossfader.
package cfx_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FADE_W      = 12;

	localparam logic [FADE_W-1:0] FADE_MIN   = 12'd128;
	localparam logic [FADE_W-1:0] FADE_MAX   = 12'd2048;
	localparam logic [FADE_W-1:0] FADE_RESET = 12'd480;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] host_sample;
		logic signed [SAMPLE_BITS-1:0] render_sample;
		logic                          want_render;
		logic                          position_valid;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic                          in_fade;
		logic                          render_mode;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MIX,
		ST_DONE
	} seq_state_t;

endpackage

/* rtl/cfx_div.sv */
// Restoring divider producing floor(frame * 2^WEIGHT_BITS / length), one quotient bit a cycle.
module cfx_div #(
	parameter int WEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cfx_pkg::FADE_W-1:0]    dividend,
	input  logic [cfx_pkg::FADE_W-1:0]    divisor,
	output logic                          done,
	output logic [WEIGHT_BITS-1:0]        quotient
);

	localparam int RW = cfx_pkg::FADE_W + 1;
	localparam int CW = $clog2(WEIGHT_BITS + 1);

	logic [RW-1:0]          rem_q;
	logic [RW-1:0]          rem_sh;
	logic [RW-1:0]          div_ext;
	logic                   ge;
	logic [cfx_pkg::FADE_W-1:0] divisor_q;
	logic [WEIGHT_BITS-1:0] quot_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;

	// The remainder always stays below the divisor, so its top bit is free for the shift.
	always_comb begin
		rem_sh  = {rem_q[RW-2:0], 1'b0};
		div_ext = {1'b0, divisor_q};
		ge      = (rem_sh >= div_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WEIGHT_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= {1'b0, dividend};
			divisor_q <= divisor;
			quot_q    <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (rem_sh - div_ext) : rem_sh;
			quot_q <= {quot_q[WEIGHT_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

/* rtl/cfx_mix.sv */
// Two-stage mixer: one multiply, then round, shift and saturate.
module cfx_mix #(
	parameter int WEIGHT_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [cfx_pkg::SAMPLE_BITS-1:0] host,
	input  logic signed [cfx_pkg::SAMPLE_BITS-1:0] rend,
	input  logic [WEIGHT_BITS:0]                   weight,
	output logic                                   done,
	output logic signed [cfx_pkg::SAMPLE_BITS-1:0] result
);

	localparam int SB = cfx_pkg::SAMPLE_BITS;
	localparam int DW = SB + 1;
	localparam int PW = DW + WEIGHT_BITS + 2;
	localparam int AW = PW + 1;
	localparam logic [AW-1:0] HALF = {{(AW-WEIGHT_BITS){1'b0}}, 1'b1, {(WEIGHT_BITS-1){1'b0}}};
	localparam logic [AW-1:0] SMAX = {{(AW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic [AW-1:0] SMIN = {{(AW-SB+1){1'b1}}, {(SB-1){1'b0}}};

	logic signed [DW-1:0]      diff;
	logic signed [WEIGHT_BITS+1:0] weight_s;
	logic signed [PW-1:0]      prod;
	logic signed [PW-1:0]      prod_s1;
	logic signed [SB-1:0]      host_s1;
	logic signed [AW-1:0]      acc;
	logic signed [AW-1:0]      shifted;
	logic signed [SB-1:0]      sat;
	logic signed [SB-1:0]      res_s2;
	logic                      v_s1;
	logic                      v_s2;

	// host*(1-r) + rend*r is formed as host*1 + (rend-host)*r to need one multiplier.
	always_comb begin
		diff     = {rend[SB-1], rend} - {host[SB-1], host};
		weight_s = {1'b0, weight};
		prod     = diff * weight_s;
	end

	always_comb begin
		acc = ($signed({{(AW-SB){host_s1[SB-1]}}, host_s1}) <<< WEIGHT_BITS)
			+ $signed({prod_s1[PW-1], prod_s1}) + $signed(HALF);
		shifted = acc >>> WEIGHT_BITS;
		if (shifted > $signed(SMAX)) begin
			sat = SMAX[SB-1:0];
		end else if (shifted < $signed(SMIN)) begin
			sat = SMIN[SB-1:0];
		end else begin
			sat = shifted[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= prod;
			host_s1 <= host;
		end
		if (v_s1) begin
			res_s2 <= sat;
		end
	end

	assign done   = v_s2;
	assign result = res_s2;

endmodule

/* rtl/passthrough_render_crossfader_core.sv */
// Path: a sample outside a fade goes from result_q into the output register once it is free;
// inside a fade the divider produces one weight bit a cycle, then the two-stage mixer runs
// once before the result is loaded. One sample is taken at a time: the next sample runs
// while the last result waits in the output register, and a result held by out_stall
// stalls the input.
// Reset: asynchronous, active low; mode passthrough, no fade running, fade length 480.
module passthrough_render_crossfader_core #(
	parameter int WEIGHT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [cfx_pkg::FADE_W-1:0]     cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cfx_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cfx_pkg::out_item_t             out_data
);

	localparam int FW = cfx_pkg::FADE_W;
	localparam int SB = cfx_pkg::SAMPLE_BITS;
	localparam logic [WEIGHT_BITS:0] ONE = {1'b1, {WEIGHT_BITS{1'b0}}};

	cfx_pkg::seq_state_t state_q, state_d;

	logic [FW-1:0]        fade_length_q;
	logic [FW-1:0]        cfg_clamped;
	logic                 mode_q;
	logic [FW-1:0]        fade_left_q;

	logic                 in_xfer;
	logic                 out_xfer;
	logic                 mode_n;
	logic [FW-1:0]        left_n;
	logic [FW-1:0]        left_upd;
	logic                 bypass;
	logic signed [SB-1:0] bypass_sample;
	logic [FW-1:0]        frame;
	logic                 last_frame;

	logic signed [SB-1:0] host_q;
	logic signed [SB-1:0] rend_q;
	logic                 last_q;
	logic signed [SB-1:0] result_q;
	logic                 fading_q;

	logic                 div_start;
	logic                 div_done;
	logic [WEIGHT_BITS-1:0] quot;
	logic [WEIGHT_BITS:0] w;
	logic [WEIGHT_BITS:0] r;
	logic                 mix_start;
	logic                 mix_done;
	logic signed [SB-1:0] mix_result;

	logic                 out_load;
	logic                 out_valid_q;
	cfx_pkg::out_item_t   out_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign out_load = (state_q == cfx_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		cfg_clamped = cfg_wr_data;
		if (cfg_wr_data < cfx_pkg::FADE_MIN) begin
			cfg_clamped = cfx_pkg::FADE_MIN;
		end else if (cfg_wr_data > cfx_pkg::FADE_MAX) begin
			cfg_clamped = cfx_pkg::FADE_MAX;
		end
	end

	// Decision for an incoming sample: a change of request flips the mode and restarts the fade.
	always_comb begin
		mode_n = mode_q;
		left_n = fade_left_q;
		if (in_data.want_render != mode_q) begin
			mode_n = in_data.want_render;
			left_n = fade_length_q;
		end
		bypass        = 1'b1;
		bypass_sample = mode_n ? in_data.render_sample : in_data.host_sample;
		left_upd      = left_n;
		frame         = '0;
		if (left_n == '0) begin
			bypass = 1'b1;
		end else if (!mode_n && !in_data.position_valid) begin
			// Fading out with no known position: drop straight to the host signal.
			left_upd      = '0;
			bypass_sample = in_data.host_sample;
		end else begin
			bypass   = 1'b0;
			left_upd = left_n - 1'b1;
			frame    = (left_n > fade_length_q) ? '0 : (fade_length_q - left_n);
		end
		last_frame = ({1'b0, frame} + 1'b1) == {1'b0, fade_length_q};
	end

	assign div_start = in_xfer && !bypass;

	always_comb begin
		w         = last_q ? ONE : {1'b0, quot};
		r         = mode_q ? w : (ONE - w);
		mix_start = (state_q == cfx_pkg::ST_DIV) && div_done;
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			cfx_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = bypass ? cfx_pkg::ST_DONE : cfx_pkg::ST_DIV;
				end
			end
			cfx_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = cfx_pkg::ST_MIX;
				end
			end
			cfx_pkg::ST_MIX: begin
				if (mix_done) begin
					state_d = cfx_pkg::ST_DONE;
				end
			end
			cfx_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = cfx_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cfx_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfx_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_length_q <= cfx_pkg::FADE_RESET;
			mode_q        <= 1'b0;
			fade_left_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				fade_length_q <= cfg_clamped;
			end
			if (in_xfer) begin
				mode_q      <= mode_n;
				fade_left_q <= left_upd;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			host_q   <= in_data.host_sample;
			rend_q   <= in_data.render_sample;
			last_q   <= last_frame;
			result_q <= bypass_sample;
			fading_q <= !bypass;
		end else if ((state_q == cfx_pkg::ST_MIX) && mix_done) begin
			result_q <= mix_result;
		end
		if (out_load) begin
			out_q.out_sample  <= result_q;
			out_q.in_fade     <= fading_q;
			out_q.render_mode <= mode_q;
		end
	end

	cfx_div #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (frame),
		.divisor  (fade_length_q),
		.done     (div_done),
		.quotient (quot)
	);

	cfx_mix #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.host   (host_q),
		.rend   (rend_q),
		.weight (r),
		.done   (mix_done),
		.result (mix_result)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == cfx_pkg::ST_DIV))
		else $error("divider finished outside the divide step");

	a_mix_done_in_mix: assert property (@(posedge clk) disable iff (!arst_n)
		mix_done |-> (state_q == cfx_pkg::ST_MIX))
		else $error("mixer finished outside the mix step");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fade_length_q >= cfx_pkg::FADE_MIN) && (fade_length_q <= cfx_pkg::FADE_MAX))
		else $error("fade length outside its range");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != cfx_pkg::ST_IDLE))
		else $error("sequencer idle right after an input transfer");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the passthrough/render crossfader core.
module tb_top;

	localparam int SAMPLE_BITS = cfx_pkg::SAMPLE_BITS;
	localparam int FADE_W = cfx_pkg::FADE_W;
	localparam int WEIGHT_BITS = 16;
	localparam longint WEIGHT_ONE = longint'(1) << WEIGHT_BITS;
	localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam logic MODE_PASS   = 1'b0;
	localparam logic MODE_RENDER = 1'b1;
	localparam int IDLE_PCT = 21;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [FADE_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	cfx_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	cfx_pkg::out_item_t out_data;

	passthrough_render_crossfader_core #(.WEIGHT_BITS(WEIGHT_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// Own copy of the crossfader state.
	logic [FADE_W-1:0] fade_len_m = cfx_pkg::FADE_RESET;
	logic              mode_m = MODE_PASS;
	logic [FADE_W-1:0] fade_left_m = '0;

	cfx_pkg::in_item_t  frames_to_send[$];
	cfx_pkg::out_item_t expected_mix[$];
	cfx_pkg::out_item_t mix_exp;
	int        errors = 0;
	int        cycle_no = 0;
	logic      last_want = MODE_PASS;

	// No idling on either side for a stretch of the run.
	wire quiet = (cycle_no >= 2000) && (cycle_no < 5000);

	function automatic cfx_pkg::out_item_t crossfade_predict(cfx_pkg::in_item_t it);
		cfx_pkg::out_item_t res;
		longint host, rend, acc, frame_n, w, rw;
		host = longint'($signed(it.host_sample));
		rend = longint'($signed(it.render_sample));
		res.in_fade = 1'b0;
		if (it.want_render != mode_m) begin
			mode_m = it.want_render;
			fade_left_m = fade_len_m;
		end
		if (fade_left_m == 0) begin
			acc = (mode_m == MODE_RENDER) ? rend : host;
		end else if (mode_m == MODE_PASS && !it.position_valid) begin
			// Heading to passthrough with no timeline position: cut the fade short.
			fade_left_m = '0;
			acc = host;
		end else begin
			frame_n = (fade_left_m > fade_len_m) ? 0 :
				longint'(fade_len_m) - longint'(fade_left_m);
			if (frame_n + 1 == longint'(fade_len_m))
				w = WEIGHT_ONE;
			else
				w = (frame_n * WEIGHT_ONE) / longint'(fade_len_m);
			rw = (mode_m == MODE_RENDER) ? w : WEIGHT_ONE - w;
			acc = host * (WEIGHT_ONE - rw) + rend * rw + WEIGHT_ONE / 2;
			acc = acc >>> WEIGHT_BITS;
			if (acc > SAMPLE_MAX)
				acc = SAMPLE_MAX;
			else if (acc < SAMPLE_MIN)
				acc = SAMPLE_MIN;
			fade_left_m = fade_left_m - 1'b1;
			res.in_fade = 1'b1;
		end
		res.out_sample = acc[SAMPLE_BITS-1:0];
		res.render_mode = mode_m;
		return res;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		logic [SAMPLE_BITS-1:0] s;
		case ($urandom_range(7))
			0: s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			1: s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			2: s = '0;
			3: s = '1;
			default: s = SAMPLE_BITS'($urandom);
		endcase
		return s;
	endfunction

	task automatic push_frame(logic [SAMPLE_BITS-1:0] host, logic [SAMPLE_BITS-1:0] rend,
			logic want, logic pos_ok);
		cfx_pkg::in_item_t it;
		it.host_sample = host;
		it.render_sample = rend;
		it.want_render = want;
		it.position_valid = pos_ok;
		frames_to_send = {frames_to_send, it};
		last_want = want;
	endtask

	// A stretch of frames with a steady request; a missing position is rare
	// toward passthrough so that such fades usually run to their end.
	task automatic queue_run(logic want, int n);
		logic pos_ok;
		for (int i = 0; i < n; i++) begin
			if (want == MODE_PASS)
				pos_ok = ($urandom_range(249) != 0);
			else
				pos_ok = ($urandom_range(7) != 0);
			push_frame(pick_sample(), pick_sample(), want, pos_ok);
		end
	endtask

	task automatic fill_phase(int budget);
		int queued;
		int run;
		logic want;
		queued = 0;
		want = last_want;
		while (queued < budget) begin
			want = ~want;
			if ($urandom_range(2) == 0)
				run = $urandom_range(1, 12);
			else if (fade_len_m >= cfx_pkg::FADE_MAX)
				run = $urandom_range(20, 60);
			else
				run = int'(fade_len_m) + $urandom_range(0, 40);
			// The last run of a phase is cut to keep the phase within its budget.
			if (run > budget - queued)
				run = budget - queued;
			queue_run(want, run);
			queued += run;
		end
	endtask

	task automatic drain();
		while (frames_to_send.size() != 0 || in_valid || expected_mix.size() != 0)
			@(posedge clk);
		repeat (WEIGHT_BITS + 10) @(posedge clk);
	endtask

	task automatic write_fade_length(logic [FADE_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (v < cfx_pkg::FADE_MIN)
			fade_len_m = cfx_pkg::FADE_MIN;
		else if (v > cfx_pkg::FADE_MAX)
			fade_len_m = cfx_pkg::FADE_MAX;
		else
			fade_len_m = v;
	endtask

	always @(posedge clk)
		cycle_no <= cycle_no + 1;

	// Driver: a transfer is predicted at the edge that accepts it.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				expected_mix = {expected_mix, crossfade_predict(in_data)};
			if (frames_to_send.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				in_data <= frames_to_send.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stalls.
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_mix.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer, got sample %0d fade %b mode %b", $time,
					$signed(out_data.out_sample), out_data.in_fade, out_data.render_mode);
			end else begin
				mix_exp = expected_mix.pop_front();
				if (out_data.out_sample !== mix_exp.out_sample) begin
					errors++;
					$display("%0t: out_sample expected %0d got %0d", $time,
						$signed(mix_exp.out_sample), $signed(out_data.out_sample));
				end
				if (out_data.in_fade !== mix_exp.in_fade) begin
					errors++;
					$display("%0t: in_fade expected %b got %b", $time,
						mix_exp.in_fade, out_data.in_fade);
				end
				if (out_data.render_mode !== mix_exp.render_mode) begin
					errors++;
					$display("%0t: render_mode expected %b got %b", $time,
						mix_exp.render_mode, out_data.render_mode);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [FADE_W-1:0] lengths[8];
		int budgets[8];
		lengths = '{12'd4095, 12'd0, 12'd127, 12'd2049, 12'd200, 12'd2048, 12'd128, 12'd333};
		budgets = '{60, 130, 100, 50, 160, 50, 150, 200};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset fade length.
		push_frame(24'h7FFFFF, 24'h800000, MODE_PASS, 1'b1);
		push_frame(24'h800000, 24'h7FFFFF, MODE_PASS, 1'b0);
		push_frame(24'h000000, 24'hFFFFFF, MODE_PASS, 1'b1);
		push_frame(24'h7FFFFF, 24'h7FFFFF, MODE_RENDER, 1'b1);
		push_frame(24'h800000, 24'h800000, MODE_RENDER, 1'b1);
		push_frame(24'h7FFFFF, 24'h800000, MODE_RENDER, 1'b1);
		push_frame(24'h800000, 24'h7FFFFF, MODE_RENDER, 1'b0);
		// Request flips back mid-fade, then the position is lost.
		push_frame(24'h7FFFFF, 24'h800000, MODE_PASS, 1'b1);
		push_frame(24'h800000, 24'h7FFFFF, MODE_PASS, 1'b1);
		push_frame(24'h123456, 24'h654321, MODE_PASS, 1'b0);
		push_frame(24'hFFFFFF, 24'h000001, MODE_PASS, 1'b1);
		push_frame(24'h7FFFFF, 24'h800000, MODE_RENDER, 1'b0);
		push_frame(24'h800000, 24'h7FFFFF, MODE_RENDER, 1'b0);
		for (int i = 0; i < 8; i++)
			push_frame(pick_sample(), pick_sample(), MODE_RENDER, i[0]);
		drain();

		// Each phase starts with a flip, so a long fade can be cut down by
		// a shorter length written in the next phase.
		for (int p = 0; p < 8; p++) begin
			write_fade_length(lengths[p]);
			fill_phase(budgets[p]);
			drain();
		end

		if (errors == 0 && expected_mix.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
